// ===== src/hsv2rgb_pkg.sv =====
// Shared widths, constants and types for the HSV to RGB pixel converter.
// Used by the channel interfaces and by the top level; no dependencies.
package hsv2rgb_pkg;

    localparam int HUE_W    = 15;
    localparam int SV_W     = 9;
    localparam int CHAN_W   = 8;
    localparam int PACKED_W = 24;
    localparam int CHROMA_W = 17;
    localparam int NUM_W    = 28;

    localparam logic [HUE_W-1:0]    FULL_CIRCLE  = 15'd23040;
    localparam logic [11:0]         SECTOR_UNITS = 12'd3840;
    localparam logic [SV_W-1:0]     ONE_Q8       = 9'd256;
    localparam logic [CHAN_W-1:0]   CHAN_MAX     = 8'd255;

    // Sector boundaries as hue units, one per 60 degrees.
    localparam logic [HUE_W-1:0] SEC1_START = 15'd3840;
    localparam logic [HUE_W-1:0] SEC2_START = 15'd7680;
    localparam logic [HUE_W-1:0] SEC3_START = 15'd11520;
    localparam logic [HUE_W-1:0] SEC4_START = 15'd15360;
    localparam logic [HUE_W-1:0] SEC5_START = 15'd19200;

    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED
    } t_sector;

    // A numerator on the scale 65536*3840 = 1.0 maps to a byte as
    // floor(n * 255 / (2^24 * 15)) = floor(n * 17 / 2^24).
    function automatic logic [CHAN_W-1:0] chan_of(input logic [NUM_W-1:0] num);
        logic [32:0] prod;
        logic [8:0]  hi;
        prod = ({5'b0, num} << 4) + {5'b0, num};
        hi   = prod[32:24];
        return (hi > {1'b0, CHAN_MAX}) ? CHAN_MAX : hi[CHAN_W-1:0];
    endfunction

endpackage

// ===== src/hsv2rgb_if.sv =====
// Valid/ready channel interfaces for HSV items in and RGB items out.
// Depends on hsv2rgb_pkg for field widths.
interface hsv2rgb_in_if;
    logic                          valid;
    logic                          ready;
    logic [hsv2rgb_pkg::HUE_W-1:0] hue;
    logic [hsv2rgb_pkg::SV_W-1:0]  saturation;
    logic [hsv2rgb_pkg::SV_W-1:0]  brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if;
    logic                             valid;
    logic                             ready;
    logic [hsv2rgb_pkg::CHAN_W-1:0]   red;
    logic [hsv2rgb_pkg::CHAN_W-1:0]   green;
    logic [hsv2rgb_pkg::CHAN_W-1:0]   blue;
    logic [hsv2rgb_pkg::PACKED_W-1:0] packed_color;

    modport source (output valid, red, green, blue, packed_color, input ready);
    modport sink   (input valid, red, green, blue, packed_color, output ready);
endinterface

// ===== src/hsv_to_rgb_pixel_converter.sv =====
// HSV to RGB pixel converter: five-stage pipeline, one item per clock.
// Throughput is one item per cycle; every stage takes a new item at each clock unless the
// output is stalled, and then all stages hold together.
// Reset (i_rst_n low, synchronous) clears all stage valid bits and holds input ready low;
// payload is not reset. Depends on hsv2rgb_pkg and the interfaces in hsv2rgb_if.sv.
module hsv_to_rgb_pixel_converter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hsv2rgb_in_if.sink           i_hsv,
    hsv2rgb_out_if.source        o_rgb
);

    localparam int STAGES = 5;

    // The whole pipeline moves when the output register is empty or being
    // drained. Bubbles move along with items, so nothing is lost or repeated.
    logic              adv;
    logic [STAGES-1:0] r_vld;

    assign adv         = ~r_vld[STAGES-1] | o_rgb.ready;
    assign i_hsv.ready = adv & i_rst_n;

    // ---------------------------------------------------------------
    // Stage 1: fold hue into one turn, clamp S and V, find the sector
    // and the weight of the secondary component within that sector.
    // The weight is 3840 - |t - 3840|: the remainder in even sectors,
    // 3840 minus the remainder in odd ones.
    // ---------------------------------------------------------------
    logic [hsv2rgb_pkg::HUE_W-1:0] n_hue;
    logic [hsv2rgb_pkg::HUE_W-1:0] n_base;
    logic [hsv2rgb_pkg::HUE_W-1:0] n_diff;
    logic [11:0]                   n_rem;
    logic [11:0]                   n_w;
    logic [hsv2rgb_pkg::SV_W-1:0]  n_sat;
    logic [hsv2rgb_pkg::SV_W-1:0]  n_val;
    hsv2rgb_pkg::t_sector          n_sec;
    logic                          n_odd;

    always_comb begin
        n_hue = (i_hsv.hue >= hsv2rgb_pkg::FULL_CIRCLE) ?
                i_hsv.hue - hsv2rgb_pkg::FULL_CIRCLE : i_hsv.hue;

        if (n_hue >= hsv2rgb_pkg::SEC5_START) begin
            n_sec  = hsv2rgb_pkg::SEC_MAG_RED;
            n_base = hsv2rgb_pkg::SEC5_START;
        end else if (n_hue >= hsv2rgb_pkg::SEC4_START) begin
            n_sec  = hsv2rgb_pkg::SEC_BLU_MAG;
            n_base = hsv2rgb_pkg::SEC4_START;
        end else if (n_hue >= hsv2rgb_pkg::SEC3_START) begin
            n_sec  = hsv2rgb_pkg::SEC_CYN_BLU;
            n_base = hsv2rgb_pkg::SEC3_START;
        end else if (n_hue >= hsv2rgb_pkg::SEC2_START) begin
            n_sec  = hsv2rgb_pkg::SEC_GRN_CYN;
            n_base = hsv2rgb_pkg::SEC2_START;
        end else if (n_hue >= hsv2rgb_pkg::SEC1_START) begin
            n_sec  = hsv2rgb_pkg::SEC_YEL_GRN;
            n_base = hsv2rgb_pkg::SEC1_START;
        end else begin
            n_sec  = hsv2rgb_pkg::SEC_RED_YEL;
            n_base = '0;
        end

        n_diff = n_hue - n_base;
        n_rem  = n_diff[11:0];
        n_odd  = (n_sec == hsv2rgb_pkg::SEC_YEL_GRN) ||
                 (n_sec == hsv2rgb_pkg::SEC_CYN_BLU) ||
                 (n_sec == hsv2rgb_pkg::SEC_MAG_RED);
        n_w    = n_odd ? hsv2rgb_pkg::SECTOR_UNITS - n_rem : n_rem;

        n_sat = (i_hsv.saturation > hsv2rgb_pkg::ONE_Q8) ?
                hsv2rgb_pkg::ONE_Q8 : i_hsv.saturation;
        n_val = (i_hsv.brightness > hsv2rgb_pkg::ONE_Q8) ?
                hsv2rgb_pkg::ONE_Q8 : i_hsv.brightness;
    end

    hsv2rgb_pkg::t_sector          r1_sec;
    logic [11:0]                   r1_w;
    logic [hsv2rgb_pkg::SV_W-1:0]  r1_sat;
    logic [hsv2rgb_pkg::SV_W-1:0]  r1_val;

    // ---------------------------------------------------------------
    // Stage 2: chroma C = V*S and offset M = V*256 - C, both Q1.16.
    // ---------------------------------------------------------------
    logic [17:0]                        n_vs;
    logic [hsv2rgb_pkg::CHROMA_W-1:0]   n_c;
    logic [hsv2rgb_pkg::CHROMA_W-1:0]   n_m;

    always_comb begin
        n_vs = r1_val * r1_sat;
        n_c  = n_vs[hsv2rgb_pkg::CHROMA_W-1:0];
        n_m  = {r1_val[hsv2rgb_pkg::CHROMA_W-9:0], 8'b0} - n_c;
    end

    hsv2rgb_pkg::t_sector               r2_sec;
    logic [11:0]                        r2_w;
    logic [hsv2rgb_pkg::CHROMA_W-1:0]   r2_c;
    logic [hsv2rgb_pkg::CHROMA_W-1:0]   r2_m;

    // ---------------------------------------------------------------
    // Stage 3: products onto the common scale 65536*3840 = 1.0.
    // C*w is the secondary part; M*3840 is the floor; (C+M)*3840 the peak.
    // ---------------------------------------------------------------
    logic [28:0]                        n_cw;
    logic [28:0]                        n_m3840;
    logic [28:0]                        n_pk3840;
    logic [hsv2rgb_pkg::CHROMA_W-1:0]   n_pk;

    always_comb begin
        n_pk     = r2_c + r2_m;
        n_cw     = {12'b0, r2_c} * {17'b0, r2_w};
        n_m3840  = {12'b0, r2_m} * {17'b0, hsv2rgb_pkg::SECTOR_UNITS};
        n_pk3840 = {12'b0, n_pk} * {17'b0, hsv2rgb_pkg::SECTOR_UNITS};
    end

    hsv2rgb_pkg::t_sector               r3_sec;
    logic [hsv2rgb_pkg::NUM_W-1:0]      r3_cw;
    logic [hsv2rgb_pkg::NUM_W-1:0]      r3_n0;
    logic [hsv2rgb_pkg::NUM_W-1:0]      r3_nc;

    // ---------------------------------------------------------------
    // Stage 4: the secondary numerator, C*w + M*3840.
    // ---------------------------------------------------------------
    logic [hsv2rgb_pkg::NUM_W-1:0] n_nx;

    assign n_nx = r3_cw + r3_n0;

    hsv2rgb_pkg::t_sector               r4_sec;
    logic [hsv2rgb_pkg::NUM_W-1:0]      r4_nx;
    logic [hsv2rgb_pkg::NUM_W-1:0]      r4_n0;
    logic [hsv2rgb_pkg::NUM_W-1:0]      r4_nc;

    // ---------------------------------------------------------------
    // Stage 5: scale each numerator to a byte and route the three
    // components to red, green and blue by sector.
    // ---------------------------------------------------------------
    logic [hsv2rgb_pkg::CHAN_W-1:0] n_bc;
    logic [hsv2rgb_pkg::CHAN_W-1:0] n_bx;
    logic [hsv2rgb_pkg::CHAN_W-1:0] n_b0;
    logic [hsv2rgb_pkg::CHAN_W-1:0] n_red;
    logic [hsv2rgb_pkg::CHAN_W-1:0] n_green;
    logic [hsv2rgb_pkg::CHAN_W-1:0] n_blue;

    always_comb begin
        n_bc = hsv2rgb_pkg::chan_of(r4_nc);
        n_bx = hsv2rgb_pkg::chan_of(r4_nx);
        n_b0 = hsv2rgb_pkg::chan_of(r4_n0);
        case (r4_sec)
            hsv2rgb_pkg::SEC_RED_YEL: begin
                n_red = n_bc; n_green = n_bx; n_blue = n_b0;
            end
            hsv2rgb_pkg::SEC_YEL_GRN: begin
                n_red = n_bx; n_green = n_bc; n_blue = n_b0;
            end
            hsv2rgb_pkg::SEC_GRN_CYN: begin
                n_red = n_b0; n_green = n_bc; n_blue = n_bx;
            end
            hsv2rgb_pkg::SEC_CYN_BLU: begin
                n_red = n_b0; n_green = n_bx; n_blue = n_bc;
            end
            hsv2rgb_pkg::SEC_BLU_MAG: begin
                n_red = n_bx; n_green = n_b0; n_blue = n_bc;
            end
            default: begin
                n_red = n_bc; n_green = n_b0; n_blue = n_bx;
            end
        endcase
    end

    logic [hsv2rgb_pkg::CHAN_W-1:0] r5_red;
    logic [hsv2rgb_pkg::CHAN_W-1:0] r5_green;
    logic [hsv2rgb_pkg::CHAN_W-1:0] r5_blue;

    // Valid bits: the only state that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_hsv.valid};
        end
    end

    // Payload registers advance with the valid bits.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_sec   <= n_sec;
            r1_w     <= n_w;
            r1_sat   <= n_sat;
            r1_val   <= n_val;

            r2_sec   <= r1_sec;
            r2_w     <= r1_w;
            r2_c     <= n_c;
            r2_m     <= n_m;

            r3_sec   <= r2_sec;
            r3_cw    <= n_cw[hsv2rgb_pkg::NUM_W-1:0];
            r3_n0    <= n_m3840[hsv2rgb_pkg::NUM_W-1:0];
            r3_nc    <= n_pk3840[hsv2rgb_pkg::NUM_W-1:0];

            r4_sec   <= r3_sec;
            r4_nx    <= n_nx;
            r4_n0    <= r3_n0;
            r4_nc    <= r3_nc;

            r5_red   <= n_red;
            r5_green <= n_green;
            r5_blue  <= n_blue;
        end
    end

    assign o_rgb.valid        = r_vld[STAGES-1];
    assign o_rgb.red          = r5_red;
    assign o_rgb.green        = r5_green;
    assign o_rgb.blue         = r5_blue;
    assign o_rgb.packed_color = {r5_red, r5_green, r5_blue};

endmodule
